// File: hdl/sbc_pkg.sv
// types, constants and per-stage helper functions for the swept box collision pipeline
// used by swept_box_collision_axis_top; no dependencies
package sbc_pkg;

  localparam int COORD_FRAC_BITS = 12;
  localparam int TIME_FRAC_BITS  = 20;

  localparam int CW    = 32;
  localparam int VW    = 26;
  localparam int LW    = 31;
  localparam int QW    = 32;
  localparam int WSW   = 35;
  localparam int AGW   = 36;
  localparam int NW    = AGW + TIME_FRAC_BITS;
  localparam int TW    = 34;
  localparam int PW    = VW + LW;
  localparam int EW    = PW + 2;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = QW / DIV_BITS;
  localparam int NS    = DIV_STAGES + 6;

  localparam logic [1:0] AXIS_NONE = 2'd0;
  localparam logic [1:0] AXIS_X    = 2'd1;
  localparam logic [1:0] AXIS_Y    = 2'd2;
  localparam logic [1:0] AXIS_Z    = 2'd3;

  localparam logic [1:0] ORDER [3]    = '{2'd1, 2'd0, 2'd2};
  localparam logic [1:0] CODE  [3]    = '{AXIS_X, AXIS_Y, AXIS_Z};
  localparam logic [1:0] OTHER [3][2] = '{'{2'd1, 2'd2}, '{2'd2, 2'd0}, '{2'd0, 2'd1}};

  typedef struct packed {
    logic [QW-1:0] num;
    logic [VW-1:0] den;
    logic [VW-1:0] rem;
    logic [QW-1:0] quo;
    logic          neg;
    logic          sat;
  } dl_t;

  typedef struct packed {
    logic signed [CW-1:0]  lo_s;
    logic signed [CW-1:0]  hi_s;
    logic signed [CW-1:0]  lo_m;
    logic signed [CW-1:0]  hi_m;
    logic signed [VW-1:0]  vel;
    logic signed [WSW-1:0] wsum;
    logic                  mgn;
    dl_t                   dv;
    logic signed [TW-1:0]  t;
    logic [LW-1:0]         tc;
    logic                  in_lim;
    logic [1:0][PW-1:0]    prod;
    logic                  hit;
  } ax_t;

  typedef struct packed {
    ax_t [2:0]     ax;
    logic [LW-1:0] limit;
    logic [1:0]    axis;
    logic [31:0]   tout;
  } pl_t;

  function automatic logic signed [TW-1:0] sx(input logic signed [CW-1:0] v);
    sx = {{(TW-CW){v[CW-1]}}, v};
  endfunction

  function automatic ax_t ax_prep(input ax_t a);
    ax_t r;
    logic signed [TW-1:0]  hs, ls, hm, lm, outer, sw, gap;
    logic signed [WSW-1:0] wsum;
    logic signed [AGW-1:0] ge;
    logic [AGW-1:0]        ag;
    logic [VW-1:0]         av;
    logic [NW-1:0]         n;
    logic signed [TW+1:0]  gap2, swn, lim;
    r = a;
    hs = sx(a.hi_s);
    ls = sx(a.lo_s);
    hm = sx(a.hi_m);
    lm = sx(a.lo_m);
    outer = ((hm > hs) ? hm : hs) - ((lm < ls) ? lm : ls);
    wsum = WSW'(hm - lm) + WSW'(hs - ls);
    ge = AGW'(outer) - AGW'(wsum);
    ag = ge[AGW-1] ? AGW'(-ge) : AGW'(ge);
    av = a.vel[VW-1] ? VW'(-a.vel) : VW'(a.vel);
    sw = hs - ls;
    gap = (a.vel > 0) ? (ls - hm) : (lm - hs);
    gap2 = (TW+2)'(gap) <<< 1;
    swn = -((TW+2)'(sw));
    lim = -((TW+2)'(2) <<< COORD_FRAC_BITS);
    n = {ag, {TIME_FRAC_BITS{1'b0}}};
    r.wsum = wsum;
    r.mgn = (gap2 > swn) && ((TW+2)'(gap) > lim);
    r.dv.neg = ge[AGW-1];
    r.dv.sat = 64'(ag) >= (64'(av) << (QW - TIME_FRAC_BITS));
    r.dv.den = av;
    r.dv.rem = VW'(n >> QW);
    r.dv.num = n[QW-1:0];
    r.dv.quo = '0;
    return r;
  endfunction

  function automatic dl_t div_step(input dl_t x);
    dl_t r;
    logic [VW:0] r2;
    r = x;
    for (int i = 0; i < DIV_BITS; i++) begin
      r2 = {r.rem, r.num[QW-1]};
      r.num = r.num << 1;
      if (r2 >= {1'b0, r.den}) begin
        r.rem = VW'(r2 - {1'b0, r.den});
        r.quo = {r.quo[QW-2:0], 1'b1};
      end else begin
        r.rem = r2[VW-1:0];
        r.quo = {r.quo[QW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic logic overlap(input ax_t b, input logic [PW-1:0] p);
    logic [PW-1:0]        mag;
    logic signed [EW-1:0] d, hm, lm, hs, ls, hi, lo, ws;
    mag = p >> TIME_FRAC_BITS;
    d = b.vel[VW-1] ? -(EW'(mag)) : EW'(mag);
    hm = EW'(b.hi_m) + d;
    lm = EW'(b.lo_m) + d;
    hs = EW'(b.hi_s);
    ls = EW'(b.lo_s);
    ws = EW'(b.wsum);
    hi = (hm > hs) ? hm : hs;
    lo = (lm < ls) ? lm : ls;
    return (hi - lo - ws) < 0;
  endfunction

endpackage

// File: hdl/swept_box_collision_axis_top.sv
// swept box collision: first contact axis and time of impact, fully pipelined
// 14 register stages; one item per cycle except while out_ready stalls
// the 8 divider stages (4 quotient bits each) set the depth
// rst (synchronous, active high) clears all stage valid bits; payload is not reset
// depends on sbc_pkg
module swept_box_collision_axis_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] static_x,
  input  logic [63:0] static_y,
  input  logic [63:0] static_z,
  input  logic [63:0] moving_x,
  input  logic [63:0] moving_y,
  input  logic [63:0] moving_z,
  input  logic signed [25:0] velocity_x,
  input  logic signed [25:0] velocity_y,
  input  logic signed [25:0] velocity_z,
  input  logic [30:0] time_limit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  hit_axis,
  output logic signed [31:0] contact_time
);

  localparam int NS = sbc_pkg::NS;
  localparam int ND = sbc_pkg::DIV_STAGES;

  sbc_pkg::pl_t st [NS];
  sbc_pkg::pl_t st_next [NS];
  logic [NS-1:0] vld;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !vld[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready = adv[0];

  always_comb begin
    logic [63:0] sb [3];
    logic [63:0] mb [3];
    logic signed [25:0] vv [3];
    logic signed [sbc_pkg::TW-1:0] tsel;
    logic done;
    logic [1:0] a;
    sb = '{static_x, static_y, static_z};
    mb = '{moving_x, moving_y, moving_z};
    vv = '{velocity_x, velocity_y, velocity_z};

    st_next[0] = st[0];
    for (int i = 0; i < 3; i++) begin
      st_next[0].ax[i].lo_s = sb[i][31:0];
      st_next[0].ax[i].hi_s = sb[i][63:32];
      st_next[0].ax[i].lo_m = mb[i][31:0];
      st_next[0].ax[i].hi_m = mb[i][63:32];
      st_next[0].ax[i].vel  = vv[i];
    end
    st_next[0].limit = time_limit;

    st_next[1] = st[0];
    for (int i = 0; i < 3; i++) begin
      st_next[1].ax[i] = sbc_pkg::ax_prep(st[0].ax[i]);
    end

    for (int k = 0; k < ND; k++) begin
      st_next[k+2] = st[k+1];
      for (int i = 0; i < 3; i++) begin
        st_next[k+2].ax[i].dv = sbc_pkg::div_step(st[k+1].ax[i].dv);
      end
    end

    // signed time, limit test and clamp
    st_next[ND+2] = st[ND+1];
    for (int i = 0; i < 3; i++) begin
      logic [sbc_pkg::TW-1:0] mag;
      logic signed [sbc_pkg::TW-1:0] t;
      mag = st[ND+1].ax[i].dv.sat ? (sbc_pkg::TW'(1) << sbc_pkg::QW)
                                  : sbc_pkg::TW'(st[ND+1].ax[i].dv.quo);
      t = st[ND+1].ax[i].dv.neg ? -$signed(mag) : $signed(mag);
      st_next[ND+2].ax[i].t = t;
      st_next[ND+2].ax[i].in_lim = t <= $signed(sbc_pkg::TW'(st[ND+1].limit));
      st_next[ND+2].ax[i].tc = t[sbc_pkg::TW-1] ? '0 : t[sbc_pkg::LW-1:0];
    end

    // displacement products for the two other axes
    st_next[ND+3] = st[ND+2];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 2; j++) begin
        logic signed [25:0] v;
        logic [25:0] av;
        v = st[ND+2].ax[sbc_pkg::OTHER[i][j]].vel;
        av = v[25] ? 26'(-v) : 26'(v);
        st_next[ND+3].ax[i].prod[j] = sbc_pkg::PW'(av) * sbc_pkg::PW'(st[ND+2].ax[i].tc);
      end
    end

    st_next[ND+4] = st[ND+3];
    for (int i = 0; i < 3; i++) begin
      st_next[ND+4].ax[i].hit = st[ND+3].ax[i].mgn
        && sbc_pkg::overlap(st[ND+3].ax[sbc_pkg::OTHER[i][0]], st[ND+3].ax[i].prod[0])
        && sbc_pkg::overlap(st[ND+3].ax[sbc_pkg::OTHER[i][1]], st[ND+3].ax[i].prod[1]);
    end

    // axis priority Y, X, Z and output saturation
    st_next[ND+5] = st[ND+4];
    done = 1'b0;
    tsel = $signed(sbc_pkg::TW'(st[ND+4].limit));
    st_next[ND+5].axis = sbc_pkg::AXIS_NONE;
    for (int n = 0; n < 3; n++) begin
      a = sbc_pkg::ORDER[n];
      if (!done && st[ND+4].ax[a].vel != '0) begin
        tsel = st[ND+4].ax[a].t;
        if (!st[ND+4].ax[a].in_lim) begin
          done = 1'b1;
        end else if (st[ND+4].ax[a].hit) begin
          st_next[ND+5].axis = sbc_pkg::CODE[a];
          done = 1'b1;
        end
      end
    end
    if (tsel > $signed(sbc_pkg::TW'(32'h7FFFFFFF))) begin
      st_next[ND+5].tout = 32'h7FFFFFFF;
    end else if (tsel < -$signed(sbc_pkg::TW'(33'h080000000))) begin
      st_next[ND+5].tout = 32'h80000000;
    end else begin
      st_next[ND+5].tout = tsel[31:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (adv[k]) begin
        st[k] <= st_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign out_valid    = vld[NS-1];
  assign hit_axis     = st[NS-1].axis;
  assign contact_time = st[NS-1].tout;

  a_free_out_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("pipeline stalled with empty output");

  a_entry: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0]) else $error("accepted item lost at entry");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit_axis) && $stable(contact_time))
    else $error("stalled output changed");

endmodule

// File: tb/swept_box_collision_axis_top_tb.sv
// testbench for swept_box_collision_axis_top: directed and random box pairs, checked
// against a behavioral predictor of axis of first contact and time of impact
// depends on sbc_pkg and swept_box_collision_axis_top
`timescale 1ns / 100ps

module swept_box_collision_axis_top_tb;

  typedef struct {
    logic [1:0]  axis;
    logic [31:0] t;
  } impact_t;

  typedef struct {
    logic [63:0] s [3];
    logic [63:0] m [3];
    logic [25:0] v [3];
    logic [30:0] lim;
  } pair_t;

  int errors = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // predictor
  function automatic longint sgn32(input logic [31:0] x);
    return longint'($signed(x));
  endfunction

  function automatic longint mx(input longint a, input longint b);
    return a > b ? a : b;
  endfunction

  function automatic longint mn(input longint a, input longint b);
    return a < b ? a : b;
  endfunction

  function automatic impact_t predict_impact(input pair_t p);
    impact_t r;
    longint ls[3], hs[3], lm[3], hm[3], vl[3], ws[3];
    longint lim, t, outer, g, ag, av, q, rm, mag, tc, sw, gp, d, o2;
    int a, b, ok, done;
    int order[3];
    order = '{1, 0, 2};
    lim = longint'(p.lim);
    t = lim;
    r.axis = sbc_pkg::AXIS_NONE;
    done = 0;
    for (int i = 0; i < 3; i++) begin
      ls[i] = sgn32(p.s[i][31:0]);
      hs[i] = sgn32(p.s[i][63:32]);
      lm[i] = sgn32(p.m[i][31:0]);
      hm[i] = sgn32(p.m[i][63:32]);
      vl[i] = longint'($signed(p.v[i]));
      ws[i] = (hm[i] - lm[i]) + (hs[i] - ls[i]);
    end
    for (int k = 0; k < 3; k++) begin
      a = order[k];
      if (done || vl[a] == 0) continue;
      outer = mx(hm[a], hs[a]) - mn(lm[a], ls[a]);
      g = outer - ws[a];
      ag = g < 0 ? -g : g;
      av = vl[a] < 0 ? -vl[a] : vl[a];
      q = ag / av;
      rm = ag % av;
      if (q >= (longint'(1) << (32 - sbc_pkg::TIME_FRAC_BITS))) mag = longint'(1) << 32;
      else mag = (q << sbc_pkg::TIME_FRAC_BITS) + ((rm << sbc_pkg::TIME_FRAC_BITS) / av);
      t = g < 0 ? -mag : mag;
      if (t > lim) begin
        done = 1;
        continue;
      end
      tc = t < 0 ? 0 : t;
      sw = hs[a] - ls[a];
      gp = vl[a] > 0 ? ls[a] - hm[a] : lm[a] - hs[a];
      if (!(2 * gp > -sw && gp > -(longint'(2) << sbc_pkg::COORD_FRAC_BITS))) continue;
      ok = 1;
      for (int j = 1; j < 3; j++) begin
        b = (a + j) % 3;
        av = vl[b] < 0 ? -vl[b] : vl[b];
        d = (av * tc) >>> sbc_pkg::TIME_FRAC_BITS;
        if (vl[b] < 0) d = -d;
        o2 = mx(hm[b] + d, hs[b]) - mn(lm[b] + d, ls[b]);
        if (!(o2 - ws[b] < 0)) ok = 0;
      end
      if (ok) begin
        r.axis = a == 0 ? sbc_pkg::AXIS_X : (a == 1 ? sbc_pkg::AXIS_Y : sbc_pkg::AXIS_Z);
        done = 1;
      end
    end
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    r.t = t[31:0];
    return r;
  endfunction

  class impact_scoreboard;
    impact_t pending[$];

    function void note_pair(input pair_t p);
      pending = {pending, predict_impact(p)};
    endfunction

    task check_impact(input logic [1:0] axis, input logic [31:0] t);
      impact_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result axis=%0d time=%h", axis, t));
        return;
      end
      e = pending.pop_front();
      if (axis !== e.axis) report($sformatf("hit_axis %0d, want %0d", axis, e.axis));
      if (t !== e.t) report($sformatf("contact_time %h, want %h", t, e.t));
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [63:0] static_x = 0, static_y = 0, static_z = 0;
  logic [63:0] moving_x = 0, moving_y = 0, moving_z = 0;
  logic signed [25:0] velocity_x = 0, velocity_y = 0, velocity_z = 0;
  logic [30:0] time_limit = 0;
  logic [1:0] hit_axis;
  logic signed [31:0] contact_time;

  swept_box_collision_axis_top DUT (.*);

  always #10 clk = ~clk;

  impact_scoreboard sb = new();
  int send_idle = 0, recv_stall = 0;
  longint cycles = 0;
  localparam longint CYCLE_LIMIT = 400000;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[swept_box_collision_axis_top] ERROR");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && out_ready) sb.check_impact(hit_axis, contact_time);

  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall);

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(3))
      0: return $urandom();
      default: return $signed($urandom_range(65536)) - 32768;
    endcase
  endfunction

  function automatic logic [63:0] rnd_box();
    logic [31:0] lo, w;
    lo = rnd_coord();
    w = $urandom_range(3) == 0 ? $urandom() : $urandom_range(40000);
    return {lo + w, lo};
  endfunction

  function automatic logic [25:0] rnd_vel();
    case ($urandom_range(4))
      0: return '0;
      1: return 26'($urandom());
      default: return 26'($signed($urandom_range(40000)) - 20000);
    endcase
  endfunction

  function automatic pair_t rnd_pair();
    pair_t p;
    for (int i = 0; i < 3; i++) begin
      p.s[i] = $urandom_range(9) == 0 ? {$urandom(), $urandom()} : rnd_box();
      p.m[i] = $urandom_range(9) == 0 ? {$urandom(), $urandom()} : rnd_box();
      if ($urandom_range(1)) p.m[i] = p.s[i] + {$urandom_range(8000), $urandom_range(8000)};
      p.v[i] = rnd_vel();
    end
    p.lim = 31'($urandom_range(2) == 0 ? $urandom() : $urandom_range(1 << 22));
    return p;
  endfunction

  task automatic send_pair(input pair_t p);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    {static_x, static_y, static_z} <= {p.s[0], p.s[1], p.s[2]};
    {moving_x, moving_y, moving_z} <= {p.m[0], p.m[1], p.m[2]};
    {velocity_x, velocity_y, velocity_z} <= {p.v[0], p.v[1], p.v[2]};
    time_limit <= p.lim;
    do @(posedge clk); while (!in_ready);
    sb.note_pair(p);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  pair_t p;

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: extremes, zero speeds, negative speeds, inverted boxes
    for (int k = 0; k < 20; k++) begin
      p = rnd_pair();
      case (k)
        0: p = '{s: '{default: 64'h0}, m: '{default: 64'h0}, v: '{default: 26'h0}, lim: 0};
        1: p = '{s: '{default: '1}, m: '{default: '1}, v: '{default: 26'h2000000},
                 lim: 31'h7fffffff};
        2: begin
          p.s = '{{32'h7fffffff, 32'h80000000}, {32'h1000, 32'h0}, {32'h1000, 32'h0}};
          p.m = '{{32'h80000000, 32'h7fffffff}, {32'h1000, 32'h0}, {32'h1000, 32'h0}};
          p.v = '{26'h1ffffff, 0, 0};
        end
        3: begin
          p.s = '{{32'h1000, 32'h0}, {32'h1000, 32'h0}, {32'h1000, 32'h0}};
          p.m = '{{32'h1000, 32'h0}, {32'h3000, 32'h2000}, {32'h1000, 32'h0}};
          p.v = '{0, -26'sd4096, 0};
          p.lim = 31'h7fffffff;
        end
        4: begin
          p.s = '{{32'h1000, 32'h0}, {32'h1000, 32'h0}, {32'h1000, 32'h0}};
          p.m = '{{32'h1000, 32'h0}, {32'h1000, 32'h0}, {32'hfffff000, 32'hffffe000}};
          p.v = '{0, 0, 26'sd1};
          p.lim = 31'h7fffffff;
        end
        5: p.v = '{26'd20480000, -26'sd20480000, 26'd1};
        6: begin
          p.s[0] = {32'h0, 32'h1000};
          p.m[0] = {32'h0, 32'h2000};
        end
        default: ;
      endcase
      send_pair(p);
    end
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = ph == 1 || ph == 3 ? (ph == 1 ? 82 : 8) : 0;
      recv_stall = ph == 2 || ph == 3 ? (ph == 2 ? 82 : 8) : 0;
      for (int k = 0; k < 235; k++) send_pair(rnd_pair());
    end
    drain();
    repeat (30) @(posedge clk);
    if (errors == 0) $display("[swept_box_collision_axis_top] OK");
    else $display("[swept_box_collision_axis_top] ERROR");
    $finish;
  end
endmodule
